@@ design/sorted_priority_queue_top_macros.svh @@
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// property checked outside reset only
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// types, codes and widths shared by the sorted priority queue modules
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  // field widths
  localparam int PRI_W      = 16;
  localparam int TAG_W      = 16;
  localparam int ENT_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 2;

  // operation codes carried in in_tuser
  typedef enum logic [IN_USER_W-1:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_t;

  // result status carried in out_tuser
  typedef enum logic [OUT_USER_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input beat
    logic commit;  // apply the operation and load the result register
  } spq_cmd_t;

endpackage

`default_nettype wire

@@ design/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// two-state controller: accepts a beat, then commits it once the result
// register is free
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // commands
  always_comb begin
    cmd.load   = in_tvalid && in_tready;
    cmd.commit = (state_r == S_EXEC) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// sorted slot row with parallel compare and shift, tail register, input
// capture and result register
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire spq_pkg::spq_cmd_t             cmd,
  input  wire logic [spq_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [spq_pkg::IN_USER_W-1:0] in_tuser,
  output logic [spq_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [spq_pkg::OUT_USER_W-1:0]     out_tuser
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // captured input beat
  logic                    op_r;
  logic signed [PRI_W-1:0] pri_r;
  logic [TAG_W-1:0]        tag_r;

  // slot row, kept sorted ascending, head at index 0
  logic signed [PRI_W-1:0] slot_pri_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]        slot_tag_r [QUEUE_DEPTH];
  logic signed [PRI_W-1:0] slot_pri_nxt [QUEUE_DEPTH];
  logic [TAG_W-1:0]        slot_tag_nxt [QUEUE_DEPTH];

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [PRI_W-1:0] rear_pri_r, rear_pri_nxt;
  logic [TAG_W-1:0]        rear_tag_r, rear_tag_nxt;

  logic [QUEUE_DEPTH-1:0]  goes_before;
  logic                    is_full, is_empty, do_insert, do_remove, at_tail;
  spq_status_t             status;
  logic signed [PRI_W-1:0] popped_pri, front_pri, rear_pri_out;
  logic [TAG_W-1:0]        popped_tag, front_tag, rear_tag_out;
  logic [CNT_W+ENT_W-1:0]  cnt_ext;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tuser[0];
      pri_r <= in_tdata[PRI_W-1:0];
      tag_r <= in_tdata[PRI_W+TAG_W-1:PRI_W];
    end
  end

  assign is_full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (cnt_r == '0);
  assign do_insert = (op_r == OP_INSERT) && !is_full;
  assign do_remove = (op_r == OP_REMOVE) && !is_empty;
  // rear holds the largest priority, so a new entry at or above it lands at the tail
  assign at_tail   = is_empty || (rear_pri_r <= pri_r);

  // per-slot compare: the new entry lands at or before slot i
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      goes_before[i] = (CNT_W'(i) >= cnt_r) || (slot_pri_r[i] > pri_r);
    end
  end

  // slot row next values
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_pri_nxt[i] = slot_pri_r[i];
      slot_tag_nxt[i] = slot_tag_r[i];
      if (do_insert && goes_before[i]) begin
        if (i == 0 || !goes_before[(i == 0) ? 0 : i-1]) begin
          slot_pri_nxt[i] = pri_r;
          slot_tag_nxt[i] = tag_r;
        end else begin
          slot_pri_nxt[i] = slot_pri_r[(i == 0) ? 0 : i-1];
          slot_tag_nxt[i] = slot_tag_r[(i == 0) ? 0 : i-1];
        end
      end else if (do_remove && i < QUEUE_DEPTH-1) begin
        slot_pri_nxt[i] = slot_pri_r[(i < QUEUE_DEPTH-1) ? i+1 : i];
        slot_tag_nxt[i] = slot_tag_r[(i < QUEUE_DEPTH-1) ? i+1 : i];
      end
    end
  end

  // count and tail entry
  always_comb begin
    cnt_nxt      = cnt_r;
    rear_pri_nxt = rear_pri_r;
    rear_tag_nxt = rear_tag_r;
    if (do_insert) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (at_tail) begin
        rear_pri_nxt = pri_r;
        rear_tag_nxt = tag_r;
      end
    end else if (do_remove) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_pri_r[i] <= slot_pri_nxt[i];
        slot_tag_r[i] <= slot_tag_nxt[i];
      end
      rear_pri_r <= rear_pri_nxt;
      rear_tag_r <= rear_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.commit) begin
      cnt_r <= cnt_nxt;
    end
  end

  // result fields
  always_comb begin
    status = ST_DONE;
    if (op_r == OP_INSERT && is_full) status = ST_FULL;
    else if (op_r == OP_REMOVE && is_empty) status = ST_EMPTY;
    popped_pri   = do_remove ? slot_pri_r[0] : '0;
    popped_tag   = do_remove ? slot_tag_r[0] : '0;
    front_pri    = (cnt_nxt == '0) ? '0 : slot_pri_nxt[0];
    front_tag    = (cnt_nxt == '0) ? '0 : slot_tag_nxt[0];
    rear_pri_out = (cnt_nxt == '0) ? '0 : rear_pri_nxt;
    rear_tag_out = (cnt_nxt == '0) ? '0 : rear_tag_nxt;
    cnt_ext      = {{ENT_W{1'b0}}, cnt_nxt};
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tuser <= status;
      out_tdata <= {3'b000, rear_tag_out, rear_pri_out, front_tag, front_pri,
                    cnt_ext[ENT_W-1:0], popped_tag, popped_pri};
    end
  end

endmodule

`default_nettype wire

@@ design/sorted_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue kept in ascending priority order, stable for ties
// ----------------------------------------------------------------------------
// usage
//   input beat: in_tuser selects insert or remove, in_tdata carries the
//   priority and tag of an entry to insert. every beat gives one result beat
//   with status in out_tuser and the popped, front and rear entries and the
//   count in out_tdata.
//   result: an accepted beat is held in the input capture registers and is
//   committed to the result register once the output register is free.
//   pacing: a new beat is taken only after the previous one is committed, set
//   by the accept state followed by the commit state of the controller; all
//   slots compare and shift in the commit cycle.
//   reset: the queue is emptied and no result is pending; slot contents are
//   left as they are, only slots below the count are ever read.
//   stall: a result waits in the output register; one further beat is
//   taken and held, with in_tready low, until that register is freed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // in_tdata: priority_req[15:0], tag[31:16]
  input  wire logic [spq_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func[0]
  input  wire logic [spq_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // out_tdata: popped_priority[15:0], popped_tag[31:16], entries[36:32],
  //   front_priority[52:37], front_tag[68:53], rear_priority[84:69],
  //   rear_tag[100:85], zero fill[103:101]
  output logic [spq_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: status[1:0]
  output logic [spq_pkg::OUT_USER_W-1:0]      out_tuser
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // controller
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // datapath
  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

@@ design/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks on the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"

module spq_checker #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [spq_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [spq_pkg::OUT_USER_W-1:0] out_tuser
);
  import spq_pkg::*;

  localparam logic [ENT_W-1:0] FULL_ENTRIES = ENT_W'(QUEUE_DEPTH);

  logic                             out_stall;
  logic [OUT_USER_W+OUT_DATA_W-1:0] out_beat;
  logic                             empty_res, full_res, empty_ok, full_ok;

  // views of the result beat
  assign out_stall = out_tvalid && !out_tready;
  assign out_beat  = {out_tuser, out_tdata};
  assign empty_res = out_tvalid && (out_tuser == ST_EMPTY);
  assign full_res  = out_tvalid && (out_tuser == ST_FULL);
  assign empty_ok  = (out_tdata[100:0] == '0);
  assign full_ok   = (out_tdata[31:0] == '0) && (out_tdata[36:32] == FULL_ENTRIES);

  // no result pending right after reset
  `SPQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

  // a stalled result beat holds
  `SPQ_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_beat), "stalled result changed")

  // remove on empty leaves an empty queue and nothing popped
  `SPQ_ASSERT(a_empty_view, empty_res |-> empty_ok, "empty result not cleared")

  // insert on full reports a full count and nothing popped
  `SPQ_ASSERT(a_full_view, full_res |-> full_ok, "full result wrong")

  // input beats are taken only while the previous one is not in flight
  `SPQ_ASSERT(a_one_in_flight, in_tvalid && in_tready |=> !in_tready, "beat accepted back to back")

endmodule

bind sorted_priority_queue_top spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ sim/tb_sorted_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top
// self-checking bench for the sorted priority queue: a behavioural copy of
// the queue predicts every result beat, which is compared field by field as
// it leaves the block, under random idling and a long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BEATS = 1750;

  // one predicted result beat
  typedef struct {
    spq_status_t       status;
    logic signed [15:0] popped_pri;
    logic [15:0]        popped_tag;
    logic [4:0]         entries;
    logic signed [15:0] front_pri;
    logic [15:0]        front_tag;
    logic signed [15:0] rear_pri;
    logic [15:0]        rear_tag;
  } queue_view_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // shared control between the test tasks and the receiver
  logic idle_on = 1'b1;
  int   hold_req = 0;
  int   error_count = 0;
  int   result_count = 0;

  // behavioural copy of the queue
  logic signed [15:0] model_pri [DEPTH];
  logic [15:0]        model_tag [DEPTH];
  int                 model_count = 0;
  queue_view_t        pending_views [$];

  sorted_priority_queue_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // apply one operation to the queue copy and return the view after it
  function automatic queue_view_t apply_queue_op(spq_op_t op, logic signed [15:0] pri,
                                                 logic [15:0] tg);
    queue_view_t v;
    int pos;
    int i;
    v.status     = ST_DONE;
    v.popped_pri = '0;
    v.popped_tag = '0;
    if (op == OP_INSERT) begin
      if (model_count >= DEPTH) begin
        v.status = ST_FULL;
      end else begin
        // stable: go behind every entry of equal priority
        pos = 0;
        while (pos < model_count && model_pri[pos] <= pri) pos++;
        for (i = model_count; i > pos; i--) begin
          model_pri[i] = model_pri[i-1];
          model_tag[i] = model_tag[i-1];
        end
        model_pri[pos] = pri;
        model_tag[pos] = tg;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        v.status = ST_EMPTY;
      end else begin
        v.popped_pri = model_pri[0];
        v.popped_tag = model_tag[0];
        for (i = 1; i < model_count; i++) begin
          model_pri[i-1] = model_pri[i];
          model_tag[i-1] = model_tag[i];
        end
        model_count--;
      end
    end
    v.entries = 5'(model_count);
    if (model_count == 0) begin
      v.front_pri = '0;
      v.front_tag = '0;
      v.rear_pri  = '0;
      v.rear_tag  = '0;
    end else begin
      v.front_pri = model_pri[0];
      v.front_tag = model_tag[0];
      v.rear_pri  = model_pri[model_count-1];
      v.rear_tag  = model_tag[model_count-1];
    end
    return v;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] error: result beat %0d: %s", $realtime, result_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s expected %h got %h", name, want, got));
  endtask

  // result checking first, then prediction of any beat taken at the same edge
  always @(posedge clk) begin
    queue_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_views.size() == 0) begin
        report_error("result beat with nothing expected");
      end else begin
        want = pending_views.pop_front();
        check_field("status", 16'(out_tuser), 16'(want.status));
        check_field("popped_priority", out_tdata[15:0], want.popped_pri);
        check_field("popped_tag", out_tdata[31:16], want.popped_tag);
        check_field("entries", 16'(out_tdata[36:32]), 16'(want.entries));
        check_field("front_priority", out_tdata[52:37], want.front_pri);
        check_field("front_tag", out_tdata[68:53], want.front_tag);
        check_field("rear_priority", out_tdata[84:69], want.rear_pri);
        check_field("rear_tag", out_tdata[100:85], want.rear_tag);
        check_field("zero fill", 16'(out_tdata[103:101]), 16'd0);
      end
      result_count++;
    end
    if (rst_n && in_tvalid && in_tready)
      pending_views.push_back(apply_queue_op(spq_op_t'(in_tuser[0]), in_tdata[15:0],
                                             in_tdata[31:16]));
  end

  // receiver: random back-pressure and a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req <= 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (idle_on) begin
        out_tready <= ($urandom_range(0, 99) >= 17);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // send one beat: optional random gap, then hold until accepted
  task automatic send_beat(spq_op_t op, logic [15:0] pri, logic [15:0] tg);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(0, 99) < 17) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tg, pri};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // priority mix: extremes, a narrow band for ties, and the full range
  function automatic logic [15:0] rand_priority();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h8000;
    if (pick == 1) return 16'h7fff;
    if (pick < 6)  return 16'($signed($urandom_range(0, 8)) - 4);
    return 16'($urandom);
  endfunction

  task automatic send_random(int ins_pct);
    if ($urandom_range(0, 99) < ins_pct)
      send_beat(OP_INSERT, rand_priority(), 16'($urandom));
    else
      send_beat(OP_REMOVE, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_remove_on_empty();
    send_beat(OP_REMOVE, 16'h1234, 16'habcd);
  endtask

  // extremes of priority and tag, ties kept in arrival order
  task automatic test_order_and_ties();
    send_beat(OP_INSERT, 16'h7fff, 16'hffff);
    send_beat(OP_INSERT, 16'h8000, 16'h0000);
    send_beat(OP_INSERT, 16'd5, 16'd1);
    send_beat(OP_INSERT, 16'd5, 16'd2);
    send_beat(OP_INSERT, 16'd5, 16'd3);
    send_beat(OP_INSERT, 16'hffff, 16'h8000);
    send_beat(OP_REMOVE, 16'h0000, 16'h0000);
    send_beat(OP_REMOVE, 16'hffff, 16'hffff);
  endtask

  // four entries are stored here; fill up and insert on a full queue
  task automatic test_fill_to_full();
    int k;
    for (k = 0; k < DEPTH - 4; k++) begin
      if (k % 3 == 0)
        send_beat(OP_INSERT, 16'd5, 16'(16'h0100 + k));
      else
        send_beat(OP_INSERT, rand_priority(), 16'($urandom));
    end
    send_beat(OP_INSERT, 16'h8000, 16'h5555);
    send_beat(OP_INSERT, 16'h7fff, 16'haaaa);
  endtask

  // a long stretch with no idling on either side
  task automatic test_back_to_back();
    int k;
    idle_on <= 1'b0;
    for (k = 0; k < 200; k++) send_random((k / 50) % 2 == 0 ? 30 : 70);
    idle_on <= 1'b1;
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    int k;
    hold_req <= HOLD_CYCLES;
    for (k = 0; k < 40; k++) send_random(60);
  endtask

  // runs of random traffic biased to drain, balance or fill the queue
  task automatic test_random_traffic(int beats);
    int sent;
    int run_len;
    int ins_pct;
    int pick;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(0, 2);
      ins_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        send_random(ins_pct);
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_remove_on_empty();
    test_order_and_ties();
    test_fill_to_full();
    test_back_to_back();
    test_output_backpressure();
    test_random_traffic(RANDOM_BEATS);
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_views.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
